// ===== src/primitive_root_test_core_assert.svh =====
// assertion macros for the primitive root test checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef PRIMITIVE_ROOT_TEST_CORE_ASSERT_SVH
`define PRIMITIVE_ROOT_TEST_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PRT_AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("primitive root test check failed");

// antecedent implies consequent in the next cycle
`define PRT_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("primitive root test check failed");

`endif

// ===== src/prt_pkg.sv =====
// shared types and microcode for the primitive root test core
// no dependencies
package prt_pkg;

    localparam int CAND_W = 16;
    localparam int PC_W   = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_CLEAR,
        OP_RED_LD,
        OP_MUL,
        OP_BASE,
        OP_POW_LD,
        OP_STORE,
        OP_MARK,
        OP_PASS,
        OP_FAIL
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_P_LT2,
        C_CLR_MORE,
        C_MUL_MORE,
        C_ACC_ZERO,
        C_SEEN
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_CLEAR = 4'd2;
    localparam t_pc PC_RED   = 4'd4;
    localparam t_pc PC_POW   = 4'd6;
    localparam t_pc PC_MUL   = 4'd7;
    localparam t_pc PC_FAIL  = 4'd12;

    // step_more reuses the clear test: step != p-1
    function automatic t_uword prog_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{OP_LATCH,  C_NO_START, PC_IDLE};
            4'd1:    w = '{OP_NOP,    C_P_LT2,    PC_FAIL};
            4'd2:    w = '{OP_CLEAR,  C_CLR_MORE, PC_CLEAR};
            4'd3:    w = '{OP_RED_LD, C_NEVER,    PC_IDLE};
            4'd4:    w = '{OP_MUL,    C_MUL_MORE, PC_RED};
            4'd5:    w = '{OP_BASE,   C_NEVER,    PC_IDLE};
            4'd6:    w = '{OP_POW_LD, C_NEVER,    PC_IDLE};
            4'd7:    w = '{OP_MUL,    C_MUL_MORE, PC_MUL};
            4'd8:    w = '{OP_STORE,  C_ACC_ZERO, PC_FAIL};
            4'd9:    w = '{OP_NOP,    C_SEEN,     PC_FAIL};
            4'd10:   w = '{OP_MARK,   C_CLR_MORE, PC_POW};
            4'd11:   w = '{OP_PASS,   C_ALWAYS,   PC_IDLE};
            default: w = '{OP_FAIL,   C_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/prt_modmul.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle while i_ctl.step is high, msb first
// depends on prt_pkg
module prt_modmul #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                      i_clk,
    input  prt_pkg::t_mul_ctl         i_ctl,
    input  logic [MOD_WIDTH-1:0]      i_mod,
    input  logic [MOD_WIDTH-1:0]      i_x,
    input  logic [(MOD_WIDTH > prt_pkg::CAND_W ? MOD_WIDTH : prt_pkg::CAND_W)-1:0] i_y,
    output logic [MOD_WIDTH-1:0]      o_acc,
    output logic                      o_more
);
    import prt_pkg::*;

    localparam int YW = (MOD_WIDTH > CAND_W) ? MOD_WIDTH : CAND_W;
    localparam int CW = $clog2(YW);
    localparam int TW = MOD_WIDTH + 2;

    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [MOD_WIDTH-1:0] r_x;
    logic [YW-1:0]        r_y;
    logic [CW-1:0]        r_cnt;
    logic [TW-1:0]        t_sum, t_p, t_p2;

    always_comb begin
        t_p   = {2'b00, i_mod};
        t_p2  = {1'b0, i_mod, 1'b0};
        t_sum = {1'b0, r_acc, 1'b0} + (r_y[YW-1] ? {2'b00, r_x} : '0);
        priority if (t_sum >= t_p2) begin
            n_acc = MOD_WIDTH'(t_sum - t_p2);
        end else if (t_sum >= t_p) begin
            n_acc = MOD_WIDTH'(t_sum - t_p);
        end else begin
            n_acc = t_sum[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_acc <= n_acc;
            r_y   <= {r_y[YW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_acc  = r_acc;
    assign o_more = (r_cnt != CW'(YW - 1));

endmodule

// ===== src/primitive_root_test_core.sv =====
// primitive root test core: microcoded sequencer over a modular multiplier
// depends on prt_pkg and prt_modmul
//
// usage:
//   write the modulus p through i_cfg_we / i_cfg_data while the core is idle;
//   reset leaves p = 2.
//   an item is taken at a clock edge with start high and busy low; busy stays
//   high until the result strobe.
//   o_valid is high for exactly one cycle with o_candidate_echo and o_is_root;
//   the receiver cannot stall, and a new item may start in that same cycle.
// sequence:
//   the core clears the seen map entries 0 to p - 1, reduces the candidate
//   through the serial multiplier, and forms each power through the serial
//   multiplier and the registered map read; a failing candidate stops at
//   its first zero or repeated power.
//   moduli below two fail before the map is cleared.
// reset clears the sequencer, the result strobe and sets the modulus to two.
module primitive_root_test_core #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [prt_pkg::CAND_W-1:0]  i_candidate,
    input  logic                        i_cfg_we,
    input  logic [MOD_WIDTH-1:0]        i_cfg_data,
    output logic                        o_valid,
    output logic [prt_pkg::CAND_W-1:0]  o_candidate_echo,
    output logic                        o_is_root
);
    import prt_pkg::*;

    localparam int YW    = (MOD_WIDTH > CAND_W) ? MOD_WIDTH : CAND_W;
    localparam int DEPTH = 2 ** MOD_WIDTH;

    t_pc                  r_pc, n_pc;
    t_uword               uw;
    logic                 jump;
    logic [CAND_W-1:0]    r_cand;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_step;
    logic [MOD_WIDTH-1:0] r_base;
    logic [MOD_WIDTH-1:0] r_pow;
    logic                 r_rd;
    logic                 r_valid;
    logic                 r_root;
    logic                 r_seen_map [DEPTH];

    t_mul_ctl             mul_ctl;
    logic [MOD_WIDTH-1:0] mul_x;
    logic [YW-1:0]        mul_y;
    logic [MOD_WIDTH-1:0] mul_acc;
    logic                 mul_more;
    logic                 mem_we;
    logic [MOD_WIDTH-1:0] mem_wa;
    logic                 mem_wd;

    prt_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_modmul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_mod  (r_mod),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_acc  (mul_acc),
        .o_more (mul_more)
    );

    always_comb begin
        uw = prog_rom(r_pc);
        unique case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_START: jump = !start;
            C_P_LT2:    jump = (r_mod < MOD_WIDTH'(2));
            C_CLR_MORE: jump = (r_step != r_mod - 1'b1);
            C_MUL_MORE: jump = mul_more;
            C_ACC_ZERO: jump = (mul_acc == '0);
            C_SEEN:     jump = r_rd;
            default:    jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : r_pc + 1'b1;

        mul_ctl.load = (uw.op == OP_RED_LD) || (uw.op == OP_POW_LD);
        mul_ctl.step = (uw.op == OP_MUL);
        if (uw.op == OP_RED_LD) begin
            mul_x = MOD_WIDTH'(1);
            mul_y = YW'(r_cand);
        end else begin
            mul_x = r_base;
            mul_y = YW'(r_pow);
        end

        mem_we = (uw.op == OP_CLEAR) || (uw.op == OP_MARK);
        mem_wa = (uw.op == OP_CLEAR) ? r_step : r_pow;
        mem_wd = (uw.op == OP_MARK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_IDLE;
            r_mod   <= MOD_WIDTH'(2);
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= (uw.op == OP_PASS) || (uw.op == OP_FAIL);
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            OP_LATCH: begin
                if (start) begin
                    r_cand <= i_candidate;
                    r_step <= '0;
                end
            end
            OP_CLEAR: r_step <= r_step + 1'b1;
            OP_BASE: begin
                r_base <= mul_acc;
                r_pow  <= MOD_WIDTH'(1);
                r_step <= '0;
            end
            OP_STORE: begin
                r_pow  <= mul_acc;
                r_step <= r_step + 1'b1;
            end
            OP_PASS:  r_root <= 1'b1;
            OP_FAIL:  r_root <= 1'b0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_seen_map[mem_wa] <= mem_wd;
        end
        r_rd <= r_seen_map[mul_acc];
    end

    assign busy             = (r_pc != PC_IDLE);
    assign o_valid          = r_valid;
    assign o_candidate_echo = r_cand;
    assign o_is_root        = r_root;

endmodule

// ===== src/prt_checker.sv =====
// port-level checks for the primitive root test core, bound to the top level
// depends on primitive_root_test_core_assert.svh
module prt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [15:0] o_candidate_echo
);
    `include "primitive_root_test_core_assert.svh"

    `PRT_AST_NEXT(a_strobe_single, o_valid, !o_valid)
    `PRT_AST_NEXT(a_accept_busy, start && !busy, busy)
    `PRT_AST_SAME(a_result_idle, o_valid, !busy)
    `PRT_AST_NEXT(a_echo_hold, busy, $stable(o_candidate_echo))

endmodule

bind primitive_root_test_core prt_checker u_prt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_candidate_echo (o_candidate_echo)
);
